@@ hdl/ssp_pkg.sv @@
package ssp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN1,
    PH_HDR2,
    PH_BODY1,
    PH_BODY2,
    PH_DONE
  } ssp_phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_WRONG_ID  = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_BAD_CHECK = 2'd3;

  localparam logic CFG_PROTOCOL = 1'b0;
  localparam logic CFG_MASK     = 1'b1;

  localparam logic [1:0]  PROTOCOL_CRC    = 2'd2;
  localparam logic [1:0]  PROTOCOL_RESET  = 2'd1;
  localparam logic [7:0]  MASK_RESET      = 8'd35;
  localparam logic [7:0]  SYNC_BYTE       = 8'hff;
  localparam logic [7:0]  SYNC2_BYTE      = 8'hfd;
  localparam logic [15:0] CRC_POLY        = 16'h8005;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic       fault;
  } ssp_result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

  localparam logic [15:0] CRC_SYNC =
    crc_byte(crc_byte(crc_byte(16'h0000, SYNC_BYTE), SYNC_BYTE), SYNC2_BYTE);

endpackage

@@ hdl/ssp_parser.sv @@
module ssp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               restart,
  input  logic [7:0]         expected_id,
  input  logic [7:0]         rx_byte,
  input  logic [1:0]         protocol_version,
  input  logic [7:0]         tolerated_error_mask,
  output ssp_pkg::ssp_result_t result
);
  import ssp_pkg::*;

  ssp_phase_t  phase, phase_next;
  logic [15:0] recent_bytes, recent_bytes_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  wanted_id, wanted_id_next;
  logic [15:0] packet_length, packet_length_next;
  logic [15:0] body_remaining, body_remaining_next;
  logic [7:0]  sum_accumulator, sum_accumulator_next;
  logic [15:0] crc_register, crc_register_next;
  logic [15:0] check_bytes, check_bytes_next;
  logic        fault_flag, fault_flag_next;

  logic        sync_seen, sync1, sync2, hdr_last;
  logic        id_bad1, len_bad1, id_bad2, len_bad2;
  logic        body1_more, body2_more, body2_two;
  logic        error_bits, is_crc;
  logic [15:0] length_less1;
  logic [15:0] check_full;
  logic [15:0] crc_step;

  assign is_crc       = (protocol_version == PROTOCOL_CRC);
  assign sync_seen    = (recent_bytes == {SYNC_BYTE, SYNC_BYTE});
  assign sync1        = sync_seen && (rx_byte != SYNC2_BYTE);
  assign sync2        = sync_seen && (rx_byte == SYNC2_BYTE);
  assign hdr_last     = (header_count == 3'd4);
  assign id_bad1      = (sum_accumulator != wanted_id);
  assign len_bad1     = (rx_byte < 8'd2);
  assign id_bad2      = (check_bytes[7:0] != wanted_id);
  assign len_bad2     = (packet_length < 16'd3);
  assign body1_more   = (body_remaining > 16'd1);
  assign body2_more   = (body_remaining > 16'd2);
  assign body2_two    = (body_remaining == 16'd2);
  assign error_bits   = ((rx_byte & ~tolerated_error_mask) != 8'h00);
  assign length_less1 = packet_length - 16'd1;
  assign check_full   = {rx_byte, check_bytes[7:0]};
  assign crc_step     = crc_byte(crc_register, rx_byte);

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (restart) begin
        phase_next = PH_HUNT;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (is_crc && sync2) begin
              phase_next = PH_HDR2;
            end else if (!is_crc && sync1) begin
              phase_next = PH_LEN1;
            end
          end
          PH_LEN1: begin
            phase_next = (id_bad1 || len_bad1) ? PH_DONE : PH_BODY1;
          end
          PH_HDR2: begin
            if (hdr_last) begin
              phase_next = (id_bad2 || len_bad2) ? PH_DONE : PH_BODY2;
            end
          end
          PH_BODY1: begin
            if (!body1_more) begin
              phase_next = PH_DONE;
            end
          end
          PH_BODY2: begin
            if (!body2_more && !body2_two) begin
              phase_next = PH_DONE;
            end
          end
          PH_DONE: phase_next = PH_DONE;
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  always_comb begin
    recent_bytes_next    = recent_bytes;
    header_count_next    = header_count;
    wanted_id_next       = wanted_id;
    packet_length_next   = packet_length;
    body_remaining_next  = body_remaining;
    sum_accumulator_next = sum_accumulator;
    crc_register_next    = crc_register;
    check_bytes_next     = check_bytes;
    fault_flag_next      = fault_flag;
    result               = '0;
    if (accept) begin
      if (restart) begin
        recent_bytes_next    = '0;
        header_count_next    = '0;
        wanted_id_next       = expected_id;
        packet_length_next   = '0;
        body_remaining_next  = '0;
        sum_accumulator_next = '0;
        crc_register_next    = '0;
        check_bytes_next     = '0;
        fault_flag_next      = 1'b0;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (is_crc && sync2) begin
              crc_register_next = CRC_SYNC;
              header_count_next = '0;
            end else if (!is_crc && sync1) begin
              sum_accumulator_next = rx_byte;
            end else begin
              recent_bytes_next = {recent_bytes[7:0], rx_byte};
            end
          end
          PH_LEN1: begin
            if (id_bad1) begin
              result = '{valid: 1'b1, data: 8'h00, last: 1'b1, status: ST_WRONG_ID,
                         fault: 1'b0};
            end else if (len_bad1) begin
              result = '{valid: 1'b1, data: 8'h00, last: 1'b1, status: ST_BAD_LEN,
                         fault: 1'b0};
            end else begin
              sum_accumulator_next = sum_accumulator + rx_byte;
              packet_length_next   = {8'h00, rx_byte};
              body_remaining_next  = {8'h00, rx_byte};
            end
          end
          PH_HDR2: begin
            crc_register_next = crc_step;
            case (header_count)
              3'd1:    check_bytes_next   = {8'h00, rx_byte};
              3'd2:    packet_length_next = {8'h00, rx_byte};
              3'd3:    packet_length_next = {rx_byte, packet_length[7:0]};
              default: ;
            endcase
            if (!hdr_last) begin
              header_count_next = header_count + 3'd1;
            end else if (id_bad2) begin
              result = '{valid: 1'b1, data: 8'h00, last: 1'b1, status: ST_WRONG_ID,
                         fault: 1'b0};
            end else if (len_bad2) begin
              result = '{valid: 1'b1, data: 8'h00, last: 1'b1, status: ST_BAD_LEN,
                         fault: 1'b0};
            end else begin
              body_remaining_next = length_less1;
              check_bytes_next    = '0;
            end
          end
          PH_BODY1: begin
            if (body_remaining == packet_length) begin
              fault_flag_next = error_bits;
            end
            if (body1_more) begin
              sum_accumulator_next = sum_accumulator + rx_byte;
              body_remaining_next  = body_remaining - 16'd1;
              result = '{valid: 1'b1, data: rx_byte, last: 1'b0, status: ST_OK,
                         fault: 1'b0};
            end else begin
              body_remaining_next = '0;
              result = '{valid: 1'b1, data: rx_byte, last: 1'b1,
                         status: (rx_byte == ~sum_accumulator) ? ST_OK : ST_BAD_CHECK,
                         fault: fault_flag_next};
            end
          end
          PH_BODY2: begin
            if (body2_more) begin
              if (body_remaining == length_less1) begin
                fault_flag_next = error_bits;
              end
              crc_register_next   = crc_step;
              body_remaining_next = body_remaining - 16'd1;
              result = '{valid: 1'b1, data: rx_byte, last: 1'b0, status: ST_OK,
                         fault: 1'b0};
            end else if (body2_two) begin
              check_bytes_next    = {8'h00, rx_byte};
              body_remaining_next = 16'd1;
              result = '{valid: 1'b1, data: rx_byte, last: 1'b0, status: ST_OK,
                         fault: 1'b0};
            end else begin
              check_bytes_next    = check_full;
              body_remaining_next = '0;
              result = '{valid: 1'b1, data: rx_byte, last: 1'b1,
                         status: (check_full == crc_register) ? ST_OK : ST_BAD_CHECK,
                         fault: fault_flag};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      recent_bytes    <= '0;
      header_count    <= '0;
      wanted_id       <= '0;
      packet_length   <= '0;
      body_remaining  <= '0;
      sum_accumulator <= '0;
      crc_register    <= '0;
      check_bytes     <= '0;
      fault_flag      <= 1'b0;
    end else begin
      phase           <= phase_next;
      recent_bytes    <= recent_bytes_next;
      header_count    <= header_count_next;
      wanted_id       <= wanted_id_next;
      packet_length   <= packet_length_next;
      body_remaining  <= body_remaining_next;
      sum_accumulator <= sum_accumulator_next;
      crc_register    <= crc_register_next;
      check_bytes     <= check_bytes_next;
      fault_flag      <= fault_flag_next;
    end
  end

endmodule

@@ hdl/ssp_out_stage.sv @@
module ssp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ssp_pkg::ssp_result_t result,
  input  logic                take,
  output logic                room,
  output logic                valid,
  output logic [7:0]          data,
  output logic                last,
  output logic [1:0]          status,
  output logic                fault
);
  import ssp_pkg::*;

  logic valid_next;

  assign room = !valid || take;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = result.valid;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // hold payload until a new valid result replaces it
  always_ff @(posedge clk) begin
    if (load && result.valid) begin
      data   <= result.data;
      last   <= result.last;
      status <= result.status;
      fault  <= result.fault;
    end
  end

endmodule

@@ hdl/servo_status_packet_receiver.sv @@
// Servo status packet receiver. Takes one request per clock unless the output
// stalls: tuser set means restart (load expected id, clear parser), otherwise
// tdata carries one received byte. Each body byte of a status packet comes out
// on the master side the cycle after its request is taken, via a single output
// register; the next request is taken while a result waits as long as that
// register is empty or being drained, so the sustained rate is one byte per
// cycle, set by the per-byte sum/CRC update in the parser. tlast marks the final
// byte of a packet, with status and fault flag. Config writes apply next cycle.
module servo_status_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // expected_id, rx_byte
  input  logic        s_axis_tuser,  // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // data_byte
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser,  // status[1:0], servo_fault
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import ssp_pkg::*;

  logic [1:0]  protocol_version;
  logic [7:0]  tolerated_error_mask;
  logic        accept;
  ssp_result_t result;
  logic [1:0]  status;
  logic        fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version     <= PROTOCOL_RESET;
      tolerated_error_mask <= MASK_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_PROTOCOL: protocol_version     <= cfg_data[1:0];
        CFG_MASK:     tolerated_error_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  ssp_parser u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (accept),
    .restart              (s_axis_tuser),
    .expected_id          (s_axis_tdata[7:0]),
    .rx_byte              (s_axis_tdata[15:8]),
    .protocol_version     (protocol_version),
    .tolerated_error_mask (tolerated_error_mask),
    .result               (result)
  );

  ssp_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .take   (m_axis_tready),
    .room   (s_axis_tready),
    .valid  (m_axis_tvalid),
    .data   (m_axis_tdata),
    .last   (m_axis_tlast),
    .status (status),
    .fault  (fault)
  );

  assign m_axis_tuser = {fault, status};

endmodule
